// File: design/qvr_pkg.sv
`timescale 1ns / 1ps

package qvr_pkg;

   // Number formats
   localparam int QUAT_WIDTH     = 16;
   localparam int QUAT_FRAC_BITS = 14;
   localparam int VEC_WIDTH      = 24;

   // Intermediate widths, all exact
   localparam int PROD1_WIDTH = QUAT_WIDTH + VEC_WIDTH;   // q * v
   localparam int PVEC_WIDTH  = PROD1_WIDTH + 2;          // sum of three products
   localparam int PROD2_WIDTH = PVEC_WIDTH + QUAT_WIDTH;  // p * q
   localparam int SUM_WIDTH   = PROD2_WIDTH + 2;          // sum of four products

   // Rounding and saturation
   localparam int SHIFT_BITS  = 2 * QUAT_FRAC_BITS;
   localparam int ACC_WIDTH   = ((SUM_WIDTH > SHIFT_BITS) ? SUM_WIDTH : SHIFT_BITS) + 1;
   localparam int SHIFT_WIDTH = ACC_WIDTH - SHIFT_BITS;
   localparam int CMP_WIDTH   = (SHIFT_WIDTH > VEC_WIDTH) ? SHIFT_WIDTH : VEC_WIDTH;

   typedef logic signed [QUAT_WIDTH-1:0]  quat_comp_type;
   typedef logic signed [VEC_WIDTH-1:0]   vec_comp_type;
   typedef logic signed [PROD1_WIDTH-1:0] prod1_type;
   typedef logic signed [PVEC_WIDTH-1:0]  pvec_type;
   typedef logic signed [PROD2_WIDTH-1:0] prod2_type;
   typedef logic signed [SUM_WIDTH-1:0]   sum_type;
   typedef logic signed [ACC_WIDTH-1:0]   acc_type;
   typedef logic signed [SHIFT_WIDTH-1:0] shift_type;
   typedef logic signed [CMP_WIDTH-1:0]   cmp_type;

   typedef struct packed {
      quat_comp_type w;
      quat_comp_type x;
      quat_comp_type y;
      quat_comp_type z;
   } quat_type;

   // Input item
   typedef struct packed {
      quat_type     quat;
      vec_comp_type vec_x;
      vec_comp_type vec_y;
      vec_comp_type vec_z;
   } req_data_type;

   // The twelve products q * v, named by quaternion and vector component
   typedef struct packed {
      prod1_type xx;
      prod1_type yy;
      prod1_type zz;
      prod1_type wx;
      prod1_type yz;
      prod1_type zy;
      prod1_type wy;
      prod1_type zx;
      prod1_type xz;
      prod1_type wz;
      prod1_type xy;
      prod1_type yx;
   } prod1_set_type;

   typedef struct packed {
      prod1_set_type prod;
      quat_type      quat;
   } stage1_type;

   // p = q * (0, v) with the quaternion carried along
   typedef struct packed {
      pvec_type pw;
      pvec_type px;
      pvec_type py;
      pvec_type pz;
      quat_type quat;
   } pquat_type;

   // The twelve products p * q, named by p component and q component
   typedef struct packed {
      prod2_type xw;
      prod2_type wx;
      prod2_type yz;
      prod2_type zy;
      prod2_type yw;
      prod2_type wy;
      prod2_type zx;
      prod2_type xz;
      prod2_type zw;
      prod2_type wz;
      prod2_type xy;
      prod2_type yx;
   } prod2_set_type;

   typedef struct packed {
      sum_type sx;
      sum_type sy;
      sum_type sz;
   } sum_set_type;

   // Result item
   typedef struct packed {
      vec_comp_type rot_x;
      vec_comp_type rot_y;
      vec_comp_type rot_z;
      logic         clipped;
   } rsp_data_type;

endpackage

// File: design/qvr_if.sv
`timescale 1ns / 1ps

// Input channel: quaternion and vector
interface qvr_req_if;
   logic                 valid;
   logic                 ready;
   qvr_pkg::quat_comp_type quat_w;
   qvr_pkg::quat_comp_type quat_x;
   qvr_pkg::quat_comp_type quat_y;
   qvr_pkg::quat_comp_type quat_z;
   qvr_pkg::vec_comp_type  vec_x;
   qvr_pkg::vec_comp_type  vec_y;
   qvr_pkg::vec_comp_type  vec_z;

   modport source (
      output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
      input  ready
   );
   modport sink (
      input  valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
      output ready
   );
endinterface

// Result channel: rotated vector and saturation flag
interface qvr_rsp_if;
   logic                  valid;
   logic                  ready;
   qvr_pkg::vec_comp_type rot_x;
   qvr_pkg::vec_comp_type rot_y;
   qvr_pkg::vec_comp_type rot_z;
   logic                  clipped;

   modport source (
      output valid, rot_x, rot_y, rot_z, clipped,
      input  ready
   );
   modport sink (
      input  valid, rot_x, rot_y, rot_z, clipped,
      output ready
   );
endinterface

// File: design/quaternion_vector_rotate.sv
`timescale 1ns / 1ps

// Quaternion vector rotation: r = q * (0, v) * conj(q), vector part only.
//
// req_chan carries one quaternion (Q2.14) and one signed vector per transfer;
// rsp_chan returns the rotated vector, rounded half up and saturated, with
// clipped set when any component was saturated. The quaternion is not
// normalized, so a non-unit quaternion scales the vector by |q|^2.
//
// An input transfer reaches rsp_chan through the five register stages in
// order (q*v products, p sums, p*q products, four-term sums, round/saturate
// output register). Throughput: one item per cycle while the receiver does
// not stall, each stage taking a new item every cycle while it can advance.
//
// Reset clears every stage valid bit; data registers are not reset.
// When rsp_chan.ready is low, full stages hold their items and bubbles are
// squeezed out; req_chan.ready falls once all five stages are full.
module quaternion_vector_rotate (
   input logic       clock,
   input logic       reset,
   qvr_req_if.sink   req_chan,
   qvr_rsp_if.source rsp_chan
);

   qvr_pkg::req_data_type req_data;
   logic                  p_valid, p_ready;
   qvr_pkg::pquat_type    p_data;
   logic                  s_valid, s_ready;
   qvr_pkg::sum_set_type  s_data;
   qvr_pkg::rsp_data_type rsp_data;

   localparam qvr_pkg::vec_comp_type VEC_MAX = {1'b0, {(qvr_pkg::VEC_WIDTH - 1){1'b1}}};
   localparam qvr_pkg::vec_comp_type VEC_MIN = ~VEC_MAX;

   always_comb begin
      req_data.quat.w = req_chan.quat_w;
      req_data.quat.x = req_chan.quat_x;
      req_data.quat.y = req_chan.quat_y;
      req_data.quat.z = req_chan.quat_z;
      req_data.vec_x  = req_chan.vec_x;
      req_data.vec_y  = req_chan.vec_y;
      req_data.vec_z  = req_chan.vec_z;
   end

   qvr_pure_mult u_pure_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_data   (req_data),
      .out_valid (p_valid),
      .out_ready (p_ready),
      .out_data  (p_data)
   );

   qvr_conj_mult u_conj_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid),
      .in_ready  (p_ready),
      .in_data   (p_data),
      .out_valid (s_valid),
      .out_ready (s_ready),
      .out_data  (s_data)
   );

   qvr_round_sat u_round_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_valid),
      .in_ready  (s_ready),
      .in_data   (s_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_data)
   );

   assign rsp_chan.rot_x   = rsp_data.rot_x;
   assign rsp_chan.rot_y   = rsp_data.rot_y;
   assign rsp_chan.rot_z   = rsp_data.rot_z;
   assign rsp_chan.clipped = rsp_data.clipped;

   // A draining output lets every stage advance, so the input is open
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.ready |-> req_chan.ready)
      else $error("input not ready while output drains");

   // The pipeline is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result valid right after reset");

   // A saturated result has at least one component at a limit
   a_clip_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.clipped) |->
         (rsp_chan.rot_x == VEC_MAX || rsp_chan.rot_x == VEC_MIN ||
          rsp_chan.rot_y == VEC_MAX || rsp_chan.rot_y == VEC_MIN ||
          rsp_chan.rot_z == VEC_MAX || rsp_chan.rot_z == VEC_MIN))
      else $error("clipped set with no component at a limit");

endmodule

// File: design/qvr_pure_mult.sv
`timescale 1ns / 1ps

// Stages 1 and 2: p = q * (0, v). Products, then three-term sums.
module qvr_pure_mult (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  qvr_pkg::req_data_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output qvr_pkg::pquat_type    out_data
);

   localparam int PW = qvr_pkg::PROD1_WIDTH;
   localparam int SW = qvr_pkg::PVEC_WIDTH;

   logic                   s1_valid_ff, s1_valid_in, s1_ready;
   qvr_pkg::stage1_type    s1_data_ff, s1_data_in;
   qvr_pkg::prod1_set_type prod;
   logic                   s2_valid_ff, s2_valid_in, s2_ready;
   qvr_pkg::pquat_type     s2_data_ff, s2_data_in;

   // Stage 1: twelve 16 x 24 products
   always_comb begin
      prod.xx = PW'(in_data.quat.x) * PW'(in_data.vec_x);
      prod.yy = PW'(in_data.quat.y) * PW'(in_data.vec_y);
      prod.zz = PW'(in_data.quat.z) * PW'(in_data.vec_z);
      prod.wx = PW'(in_data.quat.w) * PW'(in_data.vec_x);
      prod.yz = PW'(in_data.quat.y) * PW'(in_data.vec_z);
      prod.zy = PW'(in_data.quat.z) * PW'(in_data.vec_y);
      prod.wy = PW'(in_data.quat.w) * PW'(in_data.vec_y);
      prod.zx = PW'(in_data.quat.z) * PW'(in_data.vec_x);
      prod.xz = PW'(in_data.quat.x) * PW'(in_data.vec_z);
      prod.wz = PW'(in_data.quat.w) * PW'(in_data.vec_z);
      prod.xy = PW'(in_data.quat.x) * PW'(in_data.vec_y);
      prod.yx = PW'(in_data.quat.y) * PW'(in_data.vec_x);
   end

   assign s1_ready    = !s1_valid_ff || s2_ready;
   assign in_ready    = s1_ready;
   assign s1_valid_in = s1_ready ? in_valid : s1_valid_ff;

   always_comb begin
      s1_data_in = s1_data_ff;
      if (s1_ready && in_valid) begin
         s1_data_in.prod = prod;
         s1_data_in.quat = in_data.quat;
      end
   end

   // Stage 2: combine products into the four parts of p
   assign s2_ready    = !s2_valid_ff || out_ready;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_comb begin
      s2_data_in = s2_data_ff;
      if (s2_ready && s1_valid_ff) begin
         s2_data_in.pw = -SW'(s1_data_ff.prod.xx) - SW'(s1_data_ff.prod.yy)
                         - SW'(s1_data_ff.prod.zz);
         s2_data_in.px = SW'(s1_data_ff.prod.wx) + SW'(s1_data_ff.prod.yz)
                         - SW'(s1_data_ff.prod.zy);
         s2_data_in.py = SW'(s1_data_ff.prod.wy) + SW'(s1_data_ff.prod.zx)
                         - SW'(s1_data_ff.prod.xz);
         s2_data_in.pz = SW'(s1_data_ff.prod.wz) + SW'(s1_data_ff.prod.xy)
                         - SW'(s1_data_ff.prod.yx);
         s2_data_in.quat = s1_data_ff.quat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      s2_data_ff <= s2_data_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

// File: design/qvr_conj_mult.sv
`timescale 1ns / 1ps

// Stages 3 and 4: vector part of p * conj(q). Products, then four-term sums.
module qvr_conj_mult (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  qvr_pkg::pquat_type   in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output qvr_pkg::sum_set_type out_data
);

   localparam int PW = qvr_pkg::PROD2_WIDTH;
   localparam int SW = qvr_pkg::SUM_WIDTH;

   logic                   s3_valid_ff, s3_valid_in, s3_ready;
   qvr_pkg::prod2_set_type s3_data_ff, s3_data_in;
   qvr_pkg::prod2_set_type prod;
   logic                   s4_valid_ff, s4_valid_in, s4_ready;
   qvr_pkg::sum_set_type   s4_data_ff, s4_data_in;

   // Stage 3: twelve 42 x 16 products
   always_comb begin
      prod.xw = PW'(in_data.px) * PW'(in_data.quat.w);
      prod.wx = PW'(in_data.pw) * PW'(in_data.quat.x);
      prod.yz = PW'(in_data.py) * PW'(in_data.quat.z);
      prod.zy = PW'(in_data.pz) * PW'(in_data.quat.y);
      prod.yw = PW'(in_data.py) * PW'(in_data.quat.w);
      prod.wy = PW'(in_data.pw) * PW'(in_data.quat.y);
      prod.zx = PW'(in_data.pz) * PW'(in_data.quat.x);
      prod.xz = PW'(in_data.px) * PW'(in_data.quat.z);
      prod.zw = PW'(in_data.pz) * PW'(in_data.quat.w);
      prod.wz = PW'(in_data.pw) * PW'(in_data.quat.z);
      prod.xy = PW'(in_data.px) * PW'(in_data.quat.y);
      prod.yx = PW'(in_data.py) * PW'(in_data.quat.x);
   end

   assign s3_ready    = !s3_valid_ff || s4_ready;
   assign in_ready    = s3_ready;
   assign s3_valid_in = s3_ready ? in_valid : s3_valid_ff;
   assign s3_data_in  = (s3_ready && in_valid) ? prod : s3_data_ff;

   // Stage 4: signed sums; conj(q) negates the vector part of q
   assign s4_ready    = !s4_valid_ff || out_ready;
   assign s4_valid_in = s4_ready ? s3_valid_ff : s4_valid_ff;

   always_comb begin
      s4_data_in = s4_data_ff;
      if (s4_ready && s3_valid_ff) begin
         s4_data_in.sx = SW'(s3_data_ff.xw) - SW'(s3_data_ff.wx)
                         - SW'(s3_data_ff.yz) + SW'(s3_data_ff.zy);
         s4_data_in.sy = SW'(s3_data_ff.yw) - SW'(s3_data_ff.wy)
                         - SW'(s3_data_ff.zx) + SW'(s3_data_ff.xz);
         s4_data_in.sz = SW'(s3_data_ff.zw) - SW'(s3_data_ff.wz)
                         - SW'(s3_data_ff.xy) + SW'(s3_data_ff.yx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s3_data_ff <= s3_data_in;
      s4_data_ff <= s4_data_in;
   end

   assign out_valid = s4_valid_ff;
   assign out_data  = s4_data_ff;

endmodule

// File: design/qvr_round_sat.sv
`timescale 1ns / 1ps

// Stage 5: round half up, shift out the fraction, saturate. Output register.
module qvr_round_sat (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  qvr_pkg::sum_set_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output qvr_pkg::rsp_data_type out_data
);

   localparam int AW = qvr_pkg::ACC_WIDTH;
   localparam int CW = qvr_pkg::CMP_WIDTH;
   localparam int VW = qvr_pkg::VEC_WIDTH;
   localparam int SB = qvr_pkg::SHIFT_BITS;

   localparam qvr_pkg::acc_type ROUND_HALF = AW'(1) << (SB - 1);
   localparam qvr_pkg::cmp_type VEC_MAX    = {{(CW - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
   localparam qvr_pkg::cmp_type VEC_MIN    = ~VEC_MAX;

   typedef struct packed {
      qvr_pkg::vec_comp_type val;
      logic                  clip;
   } sat_type;

   function automatic sat_type round_sat(input qvr_pkg::sum_type s);
      qvr_pkg::acc_type   acc;
      qvr_pkg::shift_type shifted;
      qvr_pkg::cmp_type   ext;
      sat_type            r;
      acc     = AW'(s) + ROUND_HALF;
      shifted = $signed(acc[AW-1:SB]);
      ext     = CW'(shifted);
      if (ext > VEC_MAX) begin
         r.val  = VEC_MAX[VW-1:0];
         r.clip = 1'b1;
      end else if (ext < VEC_MIN) begin
         r.val  = VEC_MIN[VW-1:0];
         r.clip = 1'b1;
      end else begin
         r.val  = ext[VW-1:0];
         r.clip = 1'b0;
      end
      return r;
   endfunction

   logic                  valid_ff, valid_in;
   qvr_pkg::rsp_data_type data_ff, data_in;
   sat_type               sat_x, sat_y, sat_z;

   assign sat_x = round_sat(in_data.sx);
   assign sat_y = round_sat(in_data.sy);
   assign sat_z = round_sat(in_data.sz);

   // Output register, refilled whenever it is empty or being drained
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      data_in = data_ff;
      if (in_ready && in_valid) begin
         data_in.rot_x   = sat_x.val;
         data_in.rot_y   = sat_y.val;
         data_in.rot_z   = sat_z.val;
         data_in.clipped = sat_x.clip | sat_y.clip | sat_z.clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
